// ===== hw/rtl/dfd_pkg.sv =====
package dfd_pkg;

   localparam int WIDTH_W      = 16;
   localparam int SCALE_W      = 15;
   localparam int RAW_W        = 11;
   localparam int NIBBLE_W     = 4;
   localparam int FRAME_W      = 16;
   localparam int FRAME_PULSES = 16;
   localparam int PROD_W       = SCALE_W + RAW_W;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [RAW_W-1:0]   RAW_MAX           = 11'h7ff;
   localparam logic [WIDTH_W-1:0] RST_BIT_THRESHOLD = 16'd0;
   localparam logic [WIDTH_W-1:0] RST_FIRST_MIN     = 16'd0;
   localparam logic [WIDTH_W-1:0] RST_FIRST_MAX     = 16'hffff;
   localparam logic [SCALE_W-1:0] RST_FULL_SCALE    = 15'd2047;
   localparam logic               RST_ZERO_ON_ERROR = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BIT_THRESHOLD = 3'd0,
      CSR_FIRST_MIN     = 3'd1,
      CSR_FIRST_MAX     = 3'd2,
      CSR_FULL_SCALE    = 3'd3,
      CSR_ZERO_ON_ERROR = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [WIDTH_W-1:0] bit_threshold;
      logic [WIDTH_W-1:0] first_pulse_min;
      logic [WIDTH_W-1:0] first_pulse_max;
      logic [SCALE_W-1:0] throttle_full_scale;
      logic               zero_on_error;
   } cfg_type;

   typedef struct packed {
      logic             ok;
      logic [RAW_W-1:0] raw;
      logic             tele;
   } q_entry_type;

endpackage

// ===== hw/rtl/dfd_front.sv =====
module dfd_front
   import dfd_pkg::*;
#(
   parameter int MAX_PULSES = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [WIDTH_W-1:0] req_pulse_width,
   input  cfg_type            cfg,
   input  logic               q_full,
   output logic               q_push,
   output q_entry_type        q_push_entry
);

   localparam int CNT_W = $clog2(MAX_PULSES + 1);
   localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_PULSES);
   localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_PULSES);

   logic [FRAME_W-1:0] bits_ff, bits_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [WIDTH_W-1:0] first_ff, first_in;
   logic               tele_ff, tele_in;
   logic               fire;
   logic               frame_ok;
   logic [NIBBLE_W-1:0] crc_calc;

   assign req_stall = q_full;
   assign fire      = req_valid & ~q_full;

   assign crc_calc = bits_ff[15:12] ^ bits_ff[11:8] ^ bits_ff[7:4];
   assign frame_ok = (count_ff == FRAME_CNT) &&
                     (first_ff >= cfg.first_pulse_min) &&
                     (first_ff <= cfg.first_pulse_max) &&
                     (crc_calc == bits_ff[3:0]);

   always_comb begin
      bits_in  = bits_ff;
      count_in = count_ff;
      first_in = first_ff;
      tele_in  = tele_ff;
      if (fire && !req_action) begin
         bits_in = {bits_ff[FRAME_W-2:0], (req_pulse_width > cfg.bit_threshold)};
         if (count_ff == '0) begin
            first_in = req_pulse_width;
         end
         if (count_ff < MAX_CNT) begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (fire && req_action) begin
         bits_in  = '0;
         count_in = '0;
         first_in = '0;
         if (frame_ok) begin
            tele_in = bits_ff[4];
         end
      end
   end

   assign q_push            = fire & req_action & (frame_ok | cfg.zero_on_error);
   assign q_push_entry.ok   = frame_ok;
   assign q_push_entry.raw  = frame_ok ? bits_ff[15:5] : '0;
   assign q_push_entry.tele = frame_ok ? bits_ff[4] : tele_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff  <= '0;
         count_ff <= '0;
         first_ff <= '0;
         tele_ff  <= 1'b0;
      end else begin
         bits_ff  <= bits_in;
         count_ff <= count_in;
         first_ff <= first_in;
         tele_ff  <= tele_in;
      end
   end

endmodule

// ===== hw/rtl/dfd_fifo.sv =====
module dfd_fifo
   import dfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   output logic        full,
   input  logic        pop,
   output logic        empty,
   output q_entry_type pop_entry
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

   q_entry_type      mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == DEPTH_CNT);
   assign empty     = (count_ff == '0);
   assign do_push   = push & ~full;
   assign do_pop    = pop & ~empty;
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (PTR_W + 1)'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - (PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue push while full");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count overflow");

endmodule

// ===== hw/rtl/dfd_back.sv =====
module dfd_back
   import dfd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [SCALE_W-1:0] full_scale,
   input  logic               q_empty,
   input  q_entry_type        q_pop_entry,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SCALE_W-1:0] rsp_throttle,
   output logic               rsp_telemetry_request,
   output logic               rsp_frame_ok
);

   logic               s1_valid_ff, s1_valid_in;
   logic [PROD_W-1:0]  s1_prod_ff, s1_prod_in;
   logic               s1_ok_ff, s1_ok_in;
   logic               s1_tele_ff, s1_tele_in;
   logic               out_valid_ff, out_valid_in;
   logic [SCALE_W-1:0] out_thr_ff, out_thr_in;
   logic               out_tele_ff, out_tele_in;
   logic               out_ok_ff, out_ok_in;
   logic               out_free, s1_free;

   logic [SCALE_W-1:0] q_a;
   logic [RAW_W-1:0]   q_b;
   logic [SCALE_W:0]   q_y;
   logic [4:0]         q_c;
   logic [RAW_W:0]     q_z;
   logic [SCALE_W-1:0] q_res;

   assign out_free = ~out_valid_ff | ~rsp_stall;
   assign s1_free  = ~s1_valid_ff | out_free;
   assign q_pop    = ~q_empty & s1_free;

   // p / 2047: p = a*2048 + b = a*2047 + (a + b), folded twice
   always_comb begin
      q_a   = s1_prod_ff[PROD_W-1:RAW_W];
      q_b   = s1_prod_ff[RAW_W-1:0];
      q_y   = {1'b0, q_a} + {5'b0, q_b};
      q_c   = q_y[SCALE_W:RAW_W];
      q_z   = {7'b0, q_c} + {1'b0, q_y[RAW_W-1:0]};
      q_res = q_a + {10'b0, q_c} + {14'b0, (q_z >= {1'b0, RAW_MAX})};
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_prod_in   = s1_prod_ff;
      s1_ok_in     = s1_ok_ff;
      s1_tele_in   = s1_tele_ff;
      out_valid_in = out_valid_ff;
      out_thr_in   = out_thr_ff;
      out_tele_in  = out_tele_ff;
      out_ok_in    = out_ok_ff;
      if (s1_free) begin
         s1_valid_in = q_pop;
         s1_prod_in  = PROD_W'(full_scale) * PROD_W'(q_pop_entry.raw);
         s1_ok_in    = q_pop_entry.ok;
         s1_tele_in  = q_pop_entry.tele;
      end
      if (out_free) begin
         out_valid_in = s1_valid_ff;
         out_thr_in   = q_res;
         out_tele_in  = s1_tele_ff;
         out_ok_in    = s1_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_prod_ff  <= s1_prod_in;
      s1_ok_ff    <= s1_ok_in;
      s1_tele_ff  <= s1_tele_in;
      out_thr_ff  <= out_thr_in;
      out_tele_ff <= out_tele_in;
      out_ok_ff   <= out_ok_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_throttle          = out_thr_ff;
   assign rsp_telemetry_request = out_tele_ff;
   assign rsp_frame_ok          = out_ok_ff;

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_ok |-> rsp_throttle == '0)
      else $error("rejected frame with nonzero throttle");

   a_throttle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_ok |-> rsp_throttle <= full_scale)
      else $error("throttle above full scale");

endmodule

// ===== hw/rtl/dshot_frame_decoder_top.sv =====
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    action, pulse_width
// rsp_      out        rsp_valid/stall    throttle, telemetry_request, frame_ok
// csr_      in         csr_wr_en          csr_index, csr_wdata
//
// One transaction per cycle on req_ while req_stall is low; a frame end yields a
// result unless it fails and zero_on_error is clear. The front tracks the frame;
// a 4-entry queue feeds a multiply stage and a divide-by-2047 output stage.
// Synchronous reset clears frame state, queue and pipeline valids, and loads CSR defaults.
// req_stall rises only when the queue is full; rsp_stall holds the back end.
module dshot_frame_decoder_top
   import dfd_pkg::*;
#(
   parameter int MAX_PULSES = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [WIDTH_W-1:0]     req_pulse_width,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SCALE_W-1:0]     rsp_throttle,
   output logic                   rsp_telemetry_request,
   output logic                   rsp_frame_ok,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   logic        q_push, q_full, q_pop, q_empty;
   q_entry_type q_push_entry, q_pop_entry;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BIT_THRESHOLD: cfg_in.bit_threshold       = csr_wdata;
            CSR_FIRST_MIN:     cfg_in.first_pulse_min     = csr_wdata;
            CSR_FIRST_MAX:     cfg_in.first_pulse_max     = csr_wdata;
            CSR_FULL_SCALE:    cfg_in.throttle_full_scale = csr_wdata[SCALE_W-1:0];
            CSR_ZERO_ON_ERROR: cfg_in.zero_on_error       = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_threshold       <= RST_BIT_THRESHOLD;
         cfg_ff.first_pulse_min     <= RST_FIRST_MIN;
         cfg_ff.first_pulse_max     <= RST_FIRST_MAX;
         cfg_ff.throttle_full_scale <= RST_FULL_SCALE;
         cfg_ff.zero_on_error       <= RST_ZERO_ON_ERROR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dfd_front #(
      .MAX_PULSES(MAX_PULSES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_pulse_width(req_pulse_width),
      .cfg            (cfg_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_push_entry   (q_push_entry)
   );

   dfd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_push_entry),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_entry (q_pop_entry)
   );

   dfd_back u_back (
      .clock                (clock),
      .reset                (reset),
      .full_scale           (cfg_ff.throttle_full_scale),
      .q_empty              (q_empty),
      .q_pop_entry          (q_pop_entry),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_throttle         (rsp_throttle),
      .rsp_telemetry_request(rsp_telemetry_request),
      .rsp_frame_ok         (rsp_frame_ok)
   );

endmodule
